// File: hw/rtl/bnrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnrc_pkg
// Shared types and constants of the base-N range counter: field widths,
// register indexes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package bnrc_pkg;

   localparam int AMOUNT_W    = 32;
   localparam int DIGIT_W     = 8;
   localparam int POS_W       = 4;
   localparam int ACTIVE_W    = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // A digit sum never exceeds 1018, so the carry and the sum fit 10 bits.
   localparam int CARRY_W     = 10;
   localparam int DIV_CNT_W   = 6;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_REST = DIV_CNT_W'(AMOUNT_W);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SUM  = DIV_CNT_W'(CARRY_W);

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX         = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_DIGITS = 1'b1;

   localparam logic [DIGIT_W-1:0]  RADIX_RESET  = 8'd2;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV_REST,
      ST_DIV_SUM,
      ST_FINISH,
      ST_OUT_READ,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic rd_digit;
      logic start_sum;
      logic write_digit;
      logic finish;
      logic out_read;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_digit;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/bnrc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnrc_req_if
// Request channel: a valid/ready handshake that carries the binary amount.
// ----------------------------------------------------------------------------
interface bnrc_req_if
   import bnrc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, output amount, input ready);
   modport sink   (input valid, input amount, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bnrc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnrc_rsp_if
// Response channel: a valid/ready handshake that carries one digit result.
// ----------------------------------------------------------------------------
interface bnrc_rsp_if
   import bnrc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   digit_position;
   logic [DIGIT_W-1:0] start_digit;
   logic [DIGIT_W-1:0] end_digit;
   logic               wrapped;
   logic               last;

   modport source (output valid, output digit_position, output start_digit,
                   output end_digit, output wrapped, output last, input ready);
   modport sink   (input valid, input digit_position, input start_digit,
                   input end_digit, input wrapped, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/base_n_range_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base_n_range_counter
// Multi-digit counter in a configurable base that adds a binary amount per
// request and reports every active digit before and after the addition.
// ----------------------------------------------------------------------------
// Usage:
// Each request transfer on req carries a 32-bit amount. The block takes it
// apart into digits of the current radix, adds it with carry to the stored
// counter and then sends one response transfer per active digit, most
// significant first; the final one has last set and every one of them
// carries the wrapped flag of that addition.
// Each digit is a register read, 32 steps of the bit-serial divider on the
// remaining amount and 10 steps on the digit sum. The readout of each
// digit passes through a register read and a wait for the output register.
// A new request is taken as soon as the last response is in the output
// register, even while the receiver still stalls it. A stalled response
// holds its payload and pauses the readout of the next digit.
// Reset sets the counter to zero, the radix to 2 and 16 active digits at once.
// Users write registers through csr_* only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module base_n_range_counter
   import bnrc_pkg::*;
#(
   parameter int MAX_DIGITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bnrc_req_if.sink                    req,
   bnrc_rsp_if.source                  rsp,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bnrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bnrc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_amount         (req.amount),
      .cmd                (cmd),
      .status             (status),
      .rsp_digit_position (rsp.digit_position),
      .rsp_start_digit    (rsp.start_digit),
      .rsp_end_digit      (rsp.end_digit),
      .rsp_wrapped        (rsp.wrapped),
      .rsp_last           (rsp.last)
   );

endmodule
`default_nettype wire

// File: hw/rtl/bnrc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnrc_ctrl
// Controller: sequences the digit conversion and addition, then the readout
// of one result per active digit, and owns the response valid flag.
// ----------------------------------------------------------------------------
module bnrc_ctrl
   import bnrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_digit = 1'b1;
            state_in     = ST_DIV_REST;
         end
         ST_DIV_REST: begin
            if (status.div_done) begin
               cmd.start_sum = 1'b1;
               state_in      = ST_DIV_SUM;
            end
         end
         ST_DIV_SUM: begin
            if (status.div_done) begin
               cmd.write_digit = 1'b1;
               state_in        = status.last_digit ? ST_FINISH : ST_READ;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT_READ;
         end
         ST_OUT_READ: begin
            cmd.out_read = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = status.last_digit ? ST_IDLE : ST_OUT_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/bnrc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnrc_datapath
// Datapath: configuration registers, digit store and snapshot memories, a
// bit-serial restoring divider by the radix, and the response registers.
// ----------------------------------------------------------------------------
module bnrc_datapath
   import bnrc_pkg::*;
#(
   parameter int MAX_DIGITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [AMOUNT_W-1:0]    req_amount,
   input  wire cmd_type                cmd,
   output status_type                  status,
   output logic [POS_W-1:0]            rsp_digit_position,
   output logic [DIGIT_W-1:0]          rsp_start_digit,
   output logic [DIGIT_W-1:0]          rsp_end_digit,
   output logic                        rsp_wrapped,
   output logic                        rsp_last
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   logic [DIGIT_W-1:0]  radix_ff;
   logic [ACTIVE_W-1:0] active_ff;
   logic [DIGIT_W-1:0]  base;
   logic [CNT_W-1:0]    n_eff;

   logic [CNT_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    out_pos;
   logic [IDX_W-1:0]    k_addr, out_addr, rd_addr;

   logic [AMOUNT_W-1:0] rest_ff;
   logic [CARRY_W-1:0]  carry_ff;
   logic                wrapped_ff;

   logic [AMOUNT_W-1:0]  div_q_ff;
   logic [DIGIT_W-1:0]   div_r_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DIGIT_W:0]     div_trial;
   logic                 div_ge;
   logic [CARRY_W-1:0]   sum;

   logic [DIGIT_W-1:0]    store_mem [MAX_DIGITS];
   logic [DIGIT_W-1:0]    before_mem [MAX_DIGITS];
   logic [MAX_DIGITS-1:0] valid_ff;
   logic [DIGIT_W-1:0]    store_rd_ff, before_rd_ff;
   logic                  store_vld_ff;
   logic [DIGIT_W-1:0]    digit_rd;

   // Configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         active_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIX:         radix_ff  <= csr_wdata;
            CSR_ACTIVE_DIGITS: active_ff <= csr_wdata[ACTIVE_W-1:0];
            default:           ;
         endcase
      end
   end

   assign base = (radix_ff < 8'd2) ? 8'd2 : radix_ff;

   always_comb begin
      if (active_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(active_ff) > MAX_DIGITS) begin
         n_eff = CNT_W'(MAX_DIGITS);
      end else begin
         n_eff = CNT_W'(active_ff);
      end
   end

   // Digit counter: least significant first while adding, position order
   // (most significant first) while reading out.
   assign out_pos  = n_eff - k_ff - CNT_W'(1);
   assign k_addr   = k_ff[IDX_W-1:0];
   assign out_addr = out_pos[IDX_W-1:0];
   assign rd_addr  = cmd.out_read ? out_addr : k_addr;

   assign status = '{div_done: (div_cnt_ff == '0), last_digit: (k_ff == n_eff - CNT_W'(1))};

   always_comb begin
      k_in = k_ff;
      if (cmd.load_item || cmd.finish) begin
         k_in = '0;
      end else if (cmd.write_digit || cmd.out_load) begin
         k_in = k_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   // Restoring divider by the radix, one quotient bit per cycle. The sum of
   // a digit is loaded left-aligned so that only its ten bits are walked.
   assign div_trial = {div_r_ff, div_q_ff[AMOUNT_W-1]};
   assign div_ge    = (div_trial >= {1'b0, base});
   assign digit_rd  = store_vld_ff ? store_rd_ff : '0;
   assign sum       = CARRY_W'(digit_rd) + CARRY_W'(div_r_ff) + carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.rd_digit) begin
         div_cnt_ff <= DIV_STEPS_REST;
      end else if (cmd.start_sum) begin
         div_cnt_ff <= DIV_STEPS_SUM;
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_digit) begin
         div_q_ff <= rest_ff;
         div_r_ff <= '0;
      end else if (cmd.start_sum) begin
         div_q_ff <= {sum, {(AMOUNT_W - CARRY_W){1'b0}}};
         div_r_ff <= '0;
      end else if (div_cnt_ff != '0) begin
         div_q_ff <= {div_q_ff[AMOUNT_W-2:0], div_ge};
         div_r_ff <= div_ge ? DIGIT_W'(div_trial - {1'b0, base}) : div_trial[DIGIT_W-1:0];
      end
   end

   // Remaining amount, carry and overflow flag.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         rest_ff  <= req_amount;
         carry_ff <= '0;
      end else begin
         if (cmd.start_sum) begin
            rest_ff <= div_q_ff;
         end
         if (cmd.write_digit) begin
            carry_ff <= div_q_ff[CARRY_W-1:0];
         end
      end
      if (cmd.finish) begin
         wrapped_ff <= (carry_ff != '0) || (rest_ff != '0);
      end
   end

   // Digit store with per-entry valid bits so that reset reads as zero, and
   // the snapshot of the digits before the addition.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_digit) begin
         valid_ff[k_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_digit) begin
         store_mem[k_addr] <= div_r_ff;
      end
      if (cmd.rd_digit || cmd.out_read) begin
         store_rd_ff  <= store_mem[rd_addr];
         store_vld_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_sum) begin
         before_mem[k_addr] <= digit_rd;
      end
      if (cmd.out_read) begin
         before_rd_ff <= before_mem[out_addr];
      end
   end

   // Response registers.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_digit_position <= POS_W'(k_ff);
         rsp_start_digit    <= before_rd_ff;
         rsp_end_digit      <= digit_rd;
         rsp_wrapped        <= wrapped_ff;
         rsp_last           <= status.last_digit;
      end
   end

endmodule
`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base_n_range_counter. A local digit counter
// predicts every digit result of each accepted amount under the current
// radix and digit count. Results are checked in order against it while both
// handshakes idle at random and the receiver is once held off for a long time.
// ----------------------------------------------------------------------------
module tb
   import bnrc_pkg::*;
();

   localparam int NUM_DIGITS     = 16;
   localparam int TARGET_ITEMS   = 100;
   localparam int HOLD_CYCLES    = 1500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [DIGIT_W-1:0] start_digit;
      logic [DIGIT_W-1:0] end_digit;
      logic               wrapped;
      logic               last;
   } digit_result_type;

   class digit_tracker_type;
      logic [DIGIT_W-1:0]  digits [NUM_DIGITS];
      logic [DIGIT_W-1:0]  radix_reg;
      logic [ACTIVE_W-1:0] active_reg;
      digit_result_type    expected_digits [$];
      int                  errors;
      int                  results_checked;
      int                  amounts_added;

      function void clear();
         radix_reg = RADIX_RESET;
         active_reg = ACTIVE_RESET;
         foreach (digits[i]) digits[i] = '0;
         expected_digits.delete();
         errors = 0;
         results_checked = 0;
         amounts_added = 0;
      endfunction

      function void write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_RADIX) radix_reg = value;
         else if (index == CSR_ACTIVE_DIGITS) active_reg = value[ACTIVE_W-1:0];
      endfunction

      // Adds the amount digit by digit, least significant first, and queues
      // the per-digit results most significant first.
      function void add_amount(logic [AMOUNT_W-1:0] amount);
         logic [DIGIT_W-1:0] prior [NUM_DIGITS];
         int unsigned        base, count, rest, carry, sum;
         int                 k;
         logic               wrap;
         digit_result_type   item;
         base = (radix_reg < 2) ? 2 : radix_reg;
         count = active_reg;
         if (count < 1) count = 1;
         if (count > NUM_DIGITS) count = NUM_DIGITS;
         rest = amount;
         carry = 0;
         prior = digits;
         for (k = 0; k < count; k++) begin
            sum = digits[k] + (rest % base) + carry;
            digits[k] = DIGIT_W'(sum % base);
            carry = sum / base;
            rest = rest / base;
         end
         wrap = (carry != 0) || (rest != 0);
         for (k = 0; k < count; k++) begin
            item.position = POS_W'(k);
            item.start_digit = prior[count - 1 - k];
            item.end_digit = digits[count - 1 - k];
            item.wrapped = wrap;
            item.last = (k == count - 1);
            expected_digits = {expected_digits, item};
         end
         amounts_added++;
      endfunction

      function string describe(digit_result_type r);
         return $sformatf("pos %0d start %0d end %0d wrapped %0b last %0b",
                          r.position, r.start_digit, r.end_digit, r.wrapped, r.last);
      endfunction

      function void flag_error(string text);
         errors++;
         if (errors <= REPORT_LIMIT) $display("MISMATCH: %s", text);
      endfunction

      function void check_digit(digit_result_type got);
         digit_result_type want;
         results_checked++;
         if (expected_digits.size() == 0) begin
            flag_error({"unexpected result: ", describe(got)});
         end else begin
            want = expected_digits.pop_front();
            if (got.position !== want.position || got.start_digit !== want.start_digit ||
                got.end_digit !== want.end_digit || got.wrapped !== want.wrapped ||
                got.last !== want.last)
               flag_error({"expected ", describe(want), ", got ", describe(got)});
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bnrc_req_if req_ch ();
   bnrc_rsp_if rsp_ch ();

   base_n_range_counter #(.MAX_DIGITS(NUM_DIGITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   digit_tracker_type tracker = new;

   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int settings_used;
   int hold_asked;
   int hold_served;
   int quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor both channels and watch for a stuck block.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) tracker.add_amount(req_ch.amount);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_digit('{rsp_ch.digit_position, rsp_ch.start_digit,
                                  rsp_ch.end_digit, rsp_ch.wrapped, rsp_ch.last});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // The write enable stays high; the caller drops it after its last write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_csr(index, value);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] radix_value,
                                input logic [CSR_DATA_W-1:0] digits_value);
      write_register(CSR_RADIX, radix_value);
      write_register(CSR_ACTIVE_DIGITS, digits_value);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Offers one amount and returns at the edge of its transfer with valid
   // still high, so a back-to-back item keeps it high.
   task automatic send_amount(input logic [AMOUNT_W-1:0] value);
      if (items_sent < TARGET_ITEMS / 3) begin
         send_idle_pct = 34;
         recv_idle_pct = 85;
      end else if (items_sent < 2 * TARGET_ITEMS / 3) begin
         send_idle_pct = 85;
         recv_idle_pct = 34;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.amount <= value;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.expected_digits.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return AMOUNT_W'($urandom_range(0, 300));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_radix();
      case ($urandom_range(5))
         0: return 8'd2;
         1: return 8'd255;
         2: return CSR_DATA_W'($urandom_range(0, 1));
         3: return CSR_DATA_W'($urandom_range(3, 16));
         default: return CSR_DATA_W'($urandom_range(2, 255));
      endcase
   endfunction

   // Mostly short counters, since every digit runs the divider twice. The upper
   // bits of the write data are junk that the register must drop.
   function automatic logic [CSR_DATA_W-1:0] pick_digits();
      logic [ACTIVE_W-1:0] count;
      case ($urandom_range(5))
         0: count = 5'd16;
         1: count = ACTIVE_W'($urandom_range(17, 31));
         2: count = 5'd0;
         default: count = ACTIVE_W'($urandom_range(1, 6));
      endcase
      return {3'($urandom_range(7)), count};
   endfunction

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.amount <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      items_sent = 0;
      settings_used = 0;
      hold_asked = 0;
      hold_served = 0;
      tracker.clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: binary, all sixteen digits; all ones overflows.
      send_amount(32'd0);
      send_amount(32'd1);
      send_amount(32'hFFFF_FFFF);
      send_amount(32'h5555_AAAA);
      wait_idle();

      apply_setting(8'd255, 8'd16);
      send_amount(32'hFFFF_FFFF);
      send_amount(32'hFFFF_FFFF);
      send_amount(32'd0);
      wait_idle();

      // Lowering the radix leaves stored digits at or above the new base.
      apply_setting(8'd3, 8'd16);
      send_amount(32'd1);
      send_amount(32'd0);
      send_amount(32'd7);
      wait_idle();

      // Radix zero and one count as binary; zero digits count as one.
      apply_setting(8'd0, 8'd0);
      send_amount(32'd5);
      send_amount(32'd3);
      wait_idle();

      apply_setting(8'd1, 8'd31);
      send_amount(32'd100);
      send_amount(32'd0);
      wait_idle();

      // Two active digits; the upper fourteen must keep their values.
      apply_setting(8'd255, 8'hE2);
      send_amount(32'd300);
      send_amount(32'd70000);
      wait_idle();

      apply_setting(8'd10, 8'd16);
      send_amount(32'd123456789);
      send_amount(32'd0);
      wait_idle();

      // Long receiver hold-off while amounts keep coming, so the input stalls.
      apply_setting(8'd7, 8'd2);
      hold_asked++;
      repeat (6) send_amount(pick_amount());
      wait_idle();

      while (items_sent < TARGET_ITEMS) begin
         apply_setting(pick_radix(), pick_digits());
         repeat ($urandom_range(4, 10)) send_amount(pick_amount());
         wait_idle();
      end

      repeat (20) @(posedge clock);
      $display("Summary: %0d amounts added under %0d settings, %0d digit results checked,",
               tracker.amounts_added, settings_used + 1, tracker.results_checked);
      $display("         radix and digit-count extremes and one long output stall; %0d mismatches.",
               tracker.errors);
      if (tracker.errors == 0 && tracker.expected_digits.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
